// File: design/greedy_cluster_min_cut_macros.svh
// Assertion macros for the cut engine.
`ifndef GREEDY_CLUSTER_MIN_CUT_MACROS_SVH
`define GREEDY_CLUSTER_MIN_CUT_MACROS_SVH
`ifndef SYNTH
`define GCMC_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define GCMC_ASSERT_RST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define GCMC_ASSERT(lbl, clk, rstn, prop, msg)
`define GCMC_ASSERT_RST(lbl, clk, prop, msg)
`endif
`endif

// File: design/gcmc_pkg.sv
// Shared types and constants for the cut engine.
`default_nettype none
package gcmc_pkg;
  localparam int NodeBits = 5;
  localparam int Nodes    = 32;
  localparam int WBits    = 16;
  localparam int SumBits  = 21;
  localparam int CostBits = 26;
  localparam int AddrBits = 2 * NodeBits;
  localparam logic [CostBits-1:0] CostMax = '1;
  localparam logic OpWrite = 1'b0;
  localparam logic OpStart = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_WR2, ST_INIT, ST_SCAN, ST_DECIDE, ST_UPD, ST_UPDW, ST_LAST,
    ST_OUT
  } state_e;
endpackage
`default_nettype wire

// File: design/greedy_cluster_min_cut.sv
// Top level of the minimum-cut phase engine.
// Usage: s_axis words carry node_a, node_b and edge_weight, with op on s_axis_tuser.
// op write stores a symmetric weight (two memory writes) and gives no
// result. op start runs one maximum-adjacency phase from node 0 and gives one
// m_axis word with min_cost and outside_mask, with status on m_axis_tuser.
// A start first loads the connection sums, then runs n-2 absorb steps (scan,
// decide, then one read per node and a write-back per node outside the cluster
// through single-port memories) and a scan of the final node before m_axis_tvalid
// rises; an early stop on a disconnected remainder ends it sooner.
// One item is in work at a time.
// After reset a clearing pass writes zero to all 1024 weight words with
// s_axis_tready low; node_count may still be written.
// The result is held in an output register until m_axis_tready; the next item
// is accepted while it waits, but a start waits for the register to empty.
// node_count is written through cfg_we_i/cfg_wdata_i; the user must do so while the block is idle (unenforced).
`default_nettype none
`include "greedy_cluster_min_cut_macros.svh"
module greedy_cluster_min_cut (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [4:0] node_a, [9:5] node_b, [25:10] edge_weight, [31:26] zero
  input  wire logic [31:0] s_axis_tdata,
  // [0] op
  input  wire logic        s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [25:0] min_cost, [57:26] outside_mask, [63:58] zero
  output logic [63:0]      m_axis_tdata,
  // [0] status
  output logic             m_axis_tuser,
  input  wire logic        cfg_we_i,
  input  wire logic [5:0]  cfg_wdata_i
);
  import gcmc_pkg::*;

  logic [WBits-1:0] wmem [Nodes*Nodes];
  logic [SumBits-1:0] smem [Nodes];

  state_e state_q, state_d;
  logic [5:0] ncfg_q;
  logic [NodeBits-1:0] n_last;
  logic [NodeBits-1:0] a_q, b_q, v_q, pick_q;
  logic [WBits-1:0] w_q;
  logic [AddrBits:0] clr_q;
  logic [Nodes-1:0] inc_q, outm_q, best_mask_q;
  logic [CostBits:0] cut_q;
  logic [SumBits-1:0] top_q;
  logic found_q, rd_vld_q, status_q;
  logic [NodeBits-1:0] rd_v_q;
  logic [CostBits-1:0] best_cost_q;
  logic [NodeBits-1:0] remain_q;
  logic [WBits-1:0] wrd_q;
  logic [SumBits-1:0] srd_q;
  logic out_vld_q;
  logic out_st_q;
  logic [63:0] out_q;

  // effective last node index
  always_comb begin
    if (ncfg_q < 6'd2) n_last = 5'd1;
    else if (ncfg_q > 6'd32) n_last = 5'd31;
    else n_last = 5'(ncfg_q - 6'd1);
  end

  logic acc;
  assign s_axis_tready = (state_q == ST_IDLE) && !(s_axis_tuser == OpStart && out_vld_q);
  assign acc = s_axis_tvalid && s_axis_tready;

  // memory access control
  logic w_we, s_we;
  logic [AddrBits-1:0] w_addr;
  logic [WBits-1:0] w_wd;
  logic [NodeBits-1:0] s_addr;
  logic [SumBits-1:0] s_wd;
  logic rd_en;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: if (clr_q[AddrBits]) state_d = ST_IDLE;
      ST_IDLE:  if (acc) state_d = (s_axis_tuser == OpStart) ? ST_INIT : ST_WR2;
      ST_WR2:   state_d = ST_IDLE;
      ST_INIT: begin
        if (rd_vld_q && rd_v_q == n_last) state_d = (remain_q == 5'd1) ? ST_LAST : ST_SCAN;
      end
      ST_SCAN:  if (rd_vld_q && rd_v_q == n_last) state_d = ST_DECIDE;
      ST_DECIDE: begin
        if (!found_q) state_d = ST_OUT;
        else state_d = ST_UPD;
      end
      ST_UPD:   if (rd_vld_q && rd_v_q == n_last) state_d = ST_UPDW;
      // two left before this step means one left after it
      ST_UPDW:  state_d = (remain_q == 5'd2) ? ST_LAST : ST_SCAN;
      ST_LAST:  if (rd_vld_q && rd_v_q == n_last) state_d = ST_OUT;
      ST_OUT:   state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    w_we = 1'b0; w_addr = '0; w_wd = w_q;
    s_we = 1'b0; s_addr = v_q; s_wd = '0;
    rd_en = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        w_we = !clr_q[AddrBits]; w_addr = clr_q[AddrBits-1:0]; w_wd = '0;
      end
      ST_IDLE: begin
        w_we = acc && s_axis_tuser == OpWrite;
        w_addr = {s_axis_tdata[4:0], s_axis_tdata[9:5]};
        w_wd = s_axis_tdata[25:10];
      end
      ST_WR2: begin
        w_we = 1'b1; w_addr = {b_q, a_q};
      end
      ST_INIT: begin
        w_addr = {5'd0, v_q}; rd_en = (v_q <= n_last) && !(rd_vld_q && rd_v_q == n_last);
        s_we = rd_vld_q; s_addr = rd_v_q;
        s_wd = (rd_v_q == '0) ? '0 : SumBits'(wrd_q);
      end
      ST_SCAN, ST_LAST: rd_en = 1'b1;
      ST_UPD: begin
        w_addr = {pick_q, v_q}; rd_en = 1'b1;
        // write back on the following cycle using the same address slot
        s_we = rd_vld_q && !inc_q[rd_v_q]; s_addr = rd_v_q;
        s_wd = srd_q + SumBits'(wrd_q);
      end
      default: ;
    endcase
    if (state_q == ST_UPD && !s_we) s_addr = v_q;
    if (state_q == ST_UPD && s_we) s_addr = rd_v_q;
  end

  // In ST_UPD reads and write-backs alternate on the shared port,
  // so ST_UPD issues reads only when no writeback is pending.
  logic upd_rd;
  assign upd_rd = (state_q == ST_UPD) ? !rd_vld_q : 1'b1;

  always_ff @(posedge clk_i) begin
    if (w_we) wmem[w_addr] <= w_wd;
    wrd_q <= wmem[w_addr];
    if (s_we) smem[s_addr] <= s_wd;
    else srd_q <= smem[s_addr];
  end

  logic issue, rd_go;
  assign issue = rd_en && upd_rd && (state_q != ST_UPD || !(rd_vld_q));
  // no new read once the last read of a scan is back
  assign rd_go = issue && !((state_q == ST_SCAN || state_q == ST_LAST)
                            && rd_vld_q && rd_v_q == n_last);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      ncfg_q <= 6'd32;
      clr_q <= '0;
      v_q <= '0;
      rd_vld_q <= 1'b0;
      rd_v_q <= '0;
      out_vld_q <= 1'b0;
      out_st_q <= 1'b0;
      inc_q <= '0;
      best_cost_q <= CostMax;
      best_mask_q <= '0;
      status_q <= 1'b0;
      found_q <= 1'b0;
      remain_q <= '0;
      cut_q <= '0;
      top_q <= '0;
      outm_q <= '0;
      pick_q <= '0;
      a_q <= '0; b_q <= '0; w_q <= '0;
      out_q <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) ncfg_q <= cfg_wdata_i;
      if (state_q == ST_CLEAR) clr_q <= clr_q + 1'b1;
      if (state_q == ST_OUT) out_vld_q <= 1'b1;
      else if (m_axis_tready) out_vld_q <= 1'b0;
      rd_vld_q <= rd_go;
      case (state_q)
        ST_IDLE: if (acc) begin
          a_q <= s_axis_tdata[4:0]; b_q <= s_axis_tdata[9:5];
          w_q <= s_axis_tdata[25:10];
          v_q <= '0; inc_q <= 32'd1; best_cost_q <= CostMax; best_mask_q <= '0;
          status_q <= 1'b0; remain_q <= 5'(n_last);
          cut_q <= '0; top_q <= '0; found_q <= 1'b0; outm_q <= '0;
        end
        ST_INIT, ST_SCAN, ST_LAST, ST_UPD: begin
          if (rd_go) begin
            rd_v_q <= v_q; v_q <= v_q + 1'b1;
          end
          if (state_q == ST_INIT && rd_vld_q && rd_v_q == n_last) v_q <= '0;
          if ((state_q == ST_SCAN || state_q == ST_LAST) && rd_vld_q) begin
            if (!inc_q[rd_v_q]) begin
              cut_q <= cut_q + (CostBits+1)'(srd_q);
              outm_q[rd_v_q] <= 1'b1;
              if (srd_q > top_q) begin
                top_q <= srd_q; pick_q <= rd_v_q; found_q <= 1'b1;
              end
            end
            if (rd_v_q == n_last) v_q <= '0;
          end
          if (state_q == ST_UPD && rd_vld_q && rd_v_q == n_last) v_q <= '0;
        end
        ST_DECIDE: begin
          if (cut_q[CostBits-1:0] < best_cost_q && !cut_q[CostBits]) begin
            best_cost_q <= cut_q[CostBits-1:0]; best_mask_q <= outm_q;
          end
          if (!found_q) status_q <= 1'b1;
          else inc_q[pick_q] <= 1'b1;
          v_q <= '0;
        end
        ST_UPDW: begin
          remain_q <= remain_q - 1'b1;
          cut_q <= '0; top_q <= '0; found_q <= 1'b0; outm_q <= '0; v_q <= '0;
        end
        ST_OUT: begin
          out_st_q <= status_q;
          if (!status_q && cut_q[CostBits-1:0] < best_cost_q && !cut_q[CostBits]) begin
            out_q <= {6'd0, outm_q, cut_q[CostBits-1:0]};
          end else begin
            out_q <= {6'd0, best_mask_q, best_cost_q};
          end
        end
        default: ;
      endcase
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;
  assign m_axis_tuser  = out_st_q;

  `GCMC_ASSERT(a_no_in_busy, clk_i, rst_ni, (state_q != ST_IDLE) |-> !s_axis_tready, "busy accept")
  `GCMC_ASSERT(a_node0_in, clk_i, rst_ni, (state_q == ST_SCAN) |-> inc_q[0], "node 0 lost")
  `GCMC_ASSERT(a_out_hold, clk_i, rst_ni, (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata), "out changed")
endmodule
`default_nettype wire

// File: tb/sv/greedy_cluster_min_cut_tb.sv
// Testbench for the minimum-cut phase engine: scoreboard with its own cut prediction.
module greedy_cluster_min_cut_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import gcmc_pkg::*;

  typedef struct packed {
    logic [CostBits-1:0] cost;
    logic [31:0]         mask;
    logic                status;
  } cut_word_t;

  class cut_scoreboard;
    logic [WBits-1:0] weights [Nodes][Nodes];
    logic [5:0]       node_count;
    cut_word_t        pending [$];
    int               errors;

    function new();
      foreach (weights[r, c]) weights[r][c] = '0;
      node_count = 6'd32;
      errors = 0;
    endfunction

    function cut_word_t min_cut_phase();
      cut_word_t   res;
      int          n;
      logic [31:0] cluster;
      longint      sums [Nodes];
      longint      cut;
      longint      top;
      int          pick;
      bit          found;
      logic [31:0] outside;
      n = int'(node_count);
      if (n < 2) n = 2;
      if (n > Nodes) n = Nodes;
      cluster = 32'd1;
      res.cost = CostMax;
      res.mask = '0;
      res.status = 1'b0;
      for (int v = 0; v < n; v++) sums[v] = (v == 0) ? 0 : longint'(weights[0][v]);
      for (int left = n - 1; left > 1; left--) begin
        cut = 0; top = 0; pick = 0; found = 0; outside = '0;
        for (int v = 0; v < n; v++) begin
          if (!cluster[v]) begin
            cut += sums[v];
            outside[v] = 1'b1;
            if (sums[v] > top) begin
              top = sums[v]; pick = v; found = 1;
            end
          end
        end
        if (cut > longint'(CostMax)) cut = longint'(CostMax);
        if (cut < longint'(res.cost)) begin
          res.cost = CostBits'(cut); res.mask = outside;
        end
        if (!found) begin
          res.status = 1'b1;
          break;
        end
        cluster[pick] = 1'b1;
        for (int v = 0; v < n; v++)
          if (!cluster[v]) sums[v] += longint'(weights[pick][v]);
      end
      if (!res.status) begin
        for (int v = 0; v < n; v++) begin
          if (!cluster[v]) begin
            cut = sums[v];
            if (cut > longint'(CostMax)) cut = longint'(CostMax);
            if (cut < longint'(res.cost)) begin
              res.cost = CostBits'(cut); res.mask = 32'd1 << v;
            end
            break;
          end
        end
      end
      return res;
    endfunction

    function void note_word(logic op, logic [31:0] d);
      if (op == OpWrite) begin
        weights[d[4:0]][d[9:5]] = d[25:10];
        weights[d[9:5]][d[4:0]] = d[25:10];
      end else begin
        pending.push_back(min_cut_phase());
      end
    endfunction

    function void check_word(logic [63:0] d, logic st);
      cut_word_t got, exp;
      got.cost = d[25:0];
      got.mask = d[57:26];
      got.status = st;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: unexpected result word %h", $time, d);
        return;
      end
      exp = pending.pop_front();
      if (got.cost !== exp.cost) begin
        errors++;
        $display("%0t: min_cost exp %0d got %0d", $time, exp.cost, got.cost);
      end
      if (got.mask !== exp.mask) begin
        errors++;
        $display("%0t: outside_mask exp %h got %h", $time, exp.mask, got.mask);
      end
      if (got.status !== exp.status) begin
        errors++;
        $display("%0t: status exp %0d got %0d", $time, exp.status, got.status);
      end
    endfunction
  endclass

  logic        clk_i, rst_ni;
  logic        s_axis_tvalid, s_axis_tready;
  logic [31:0] s_axis_tdata;
  logic        s_axis_tuser;
  logic        m_axis_tvalid, m_axis_tready;
  logic [63:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        cfg_we_i;
  logic [5:0]  cfg_wdata_i;

  cut_scoreboard sb;
  int  send_idle_pct, recv_idle_pct;
  bit  hold_off;

  greedy_cluster_min_cut dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #100ms;
    $display("Verification failed");
    $finish;
  end

  // receiver: random stalls plus an optional long hold-off
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      m_axis_tready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i)
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_word(m_axis_tdata, m_axis_tuser);

  task automatic send_word(logic op, logic [31:0] d);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = op;
    s_axis_tdata  = d;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_word(op, d);
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
  endtask

  function automatic logic [31:0] edge_word(int a, int b, int w);
    return {6'd0, w[15:0], b[4:0], a[4:0]};
  endfunction

  function automatic logic [31:0] start_word();
    return $urandom;  // data bits are ignored on a start
  endfunction

  task automatic drain();
    int guard;
    guard = 0;
    while (sb.pending.size() != 0 && guard < 200000) begin
      @(negedge clk_i);
      guard++;
    end
    repeat (1200) @(negedge clk_i);
  endtask

  task automatic set_nodes(logic [5:0] n);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= n;
    sb.node_count = n;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // random graph of n nodes: random edges with extreme, zero or small weights, optionally sparse, some out of range
  task automatic random_graph(int n, int edges, bit sparse);
    int a, b, w;
    for (int i = 0; i < edges; i++) begin
      a = $urandom_range(n - 1);
      b = $urandom_range(n - 1);
      case ($urandom_range(5))
        0: w = 16'hFFFF;
        1: w = 0;
        2: w = $urandom_range(3);
        default: w = $urandom_range(16'hFFFF);
      endcase
      if (sparse && $urandom_range(1)) w = 0;
      if ($urandom_range(19) == 0) begin
        a = $urandom_range(31); b = $urandom_range(31);
      end
      send_word(OpWrite, edge_word(a, b, w));
    end
  endtask

  initial begin
    int n;
    sb = new();
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    hold_off      = 1'b0;
    send_idle_pct = 7;
    recv_idle_pct = 73;
    rst_ni = 1'b0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: empty graph, full width, extremes, self loop, out-of-range endpoints
    send_word(OpStart, start_word());
    drain();
    set_nodes(6'd4);
    send_word(OpWrite, edge_word(0, 1, 16'hFFFF));
    send_word(OpWrite, edge_word(1, 2, 1));
    send_word(OpWrite, edge_word(2, 3, 16'hFFFF));
    send_word(OpWrite, edge_word(3, 3, 16'hFFFF));
    send_word(OpWrite, edge_word(31, 30, 16'hAAAA));
    send_word(OpStart, start_word());
    send_word(OpWrite, edge_word(1, 2, 0));
    send_word(OpStart, start_word());
    drain();
    set_nodes(6'd0);
    send_word(OpStart, start_word());
    drain();
    set_nodes(6'd1);
    send_word(OpStart, start_word());
    drain();
    set_nodes(6'd63);
    for (int v = 1; v < 32; v++) send_word(OpWrite, edge_word(v - 1, v, 16'hFFFF - v));
    send_word(OpStart, start_word());
    send_word(OpWrite, edge_word(0, 31, 16'h5555));
    send_word(OpStart, start_word());
    drain();
    set_nodes(6'd32);

    for (int ph = 0; ph < 3; ph++) begin
      if (ph == 1) begin send_idle_pct = 73; recv_idle_pct = 7; end
      if (ph == 2) begin send_idle_pct = 0;  recv_idle_pct = 0; end
      for (int k = 0; k < 12; k++) begin
        n = ($urandom_range(5) == 0) ? 32 : $urandom_range(2, 8);
        drain();
        set_nodes(n[5:0]);
        if ($urandom_range(3) == 0)
          for (int v = 0; v < 32; v++)
            send_word(OpWrite, edge_word(v, $urandom_range(31), 0));
        random_graph(n, $urandom_range(2, 12), $urandom_range(1));
        send_word(OpStart, start_word());
        if (ph == 2 && k == 0) begin
          hold_off = 1'b1;
          fork
            begin
              repeat (3000) @(negedge clk_i);
              hold_off = 1'b0;
            end
          join_none
          for (int j = 0; j < 4; j++) begin
            send_word(OpWrite, edge_word($urandom_range(n - 1), $urandom_range(n - 1),
                                         $urandom_range(16'hFFFF)));
            send_word(OpStart, start_word());
          end
        end
      end
    end
    drain();

    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end
endmodule
